// ===== hdl/crcfr_pkg.sv =====
// Shared constants, types and the CRC-8 byte update for the framed receiver.
// No dependencies; imported by crcfr_frame, crcfr_scale and the top level.
`default_nettype none

package crcfr_pkg;

    localparam logic [7:0]  HDR_BYTE  = 8'hA5;
    localparam logic [7:0]  CRC_POLY  = 8'h8C;
    localparam logic [3:0]  CHECK_POS = 4'd8;
    localparam logic [3:0]  POS_SPD_LO = 4'd4;
    localparam logic [3:0]  POS_SPD_HI = 4'd5;
    localparam logic [3:0]  POS_TEMP   = 4'd6;
    localparam logic [15:0] SCALE_MUL = 16'd55000;
    localparam logic [14:0] SCALE_DIV = 15'd32767;

    // Fields of a checked frame handed to the scaling pipeline.
    typedef struct packed {
        logic [15:0] raw;
        logic [7:0]  temp;
    } t_frame_res;

    // Reflected CRC-8, one byte, LSB first.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crcfr_frame.sv =====
// Header hunt, frame byte counter, running CRC-8 and field capture.
// Depends on crcfr_pkg; feeds one checked frame result to crcfr_scale.
`default_nettype none

module crcfr_frame
    import crcfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_take,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_take,
    output t_frame_res      o_res
);

    logic       r_in_frame, n_in_frame;
    logic [3:0] r_count, n_count;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_spd_lo, n_spd_lo;
    logic [7:0] r_spd_hi, n_spd_hi;
    logic [7:0] r_temp, n_temp;
    logic       r_res_valid, n_res_valid;
    t_frame_res r_res, n_res;
    logic       accept;

    assign o_take = !r_res_valid || i_res_take;
    assign accept = i_valid && o_take;

    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_crc       = r_crc;
        n_spd_lo    = r_spd_lo;
        n_spd_hi    = r_spd_hi;
        n_temp      = r_temp;
        n_res_valid = r_res_valid && !i_res_take;
        n_res       = r_res;
        if (accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == HDR_BYTE) begin
                    n_in_frame = 1'b1;
                    n_count    = 4'd1;
                    n_crc      = crc_feed(8'd0, i_rx_byte);
                end else begin
                    n_count = 4'd0;
                end
            end else if (r_count >= CHECK_POS) begin
                // Check byte: emit on match, drop otherwise, resume hunting.
                if (i_rx_byte == r_crc) begin
                    n_res_valid = 1'b1;
                    n_res.raw   = {r_spd_hi, r_spd_lo};
                    n_res.temp  = r_temp;
                end
                n_in_frame = 1'b0;
                n_count    = 4'd0;
            end else begin
                if (r_count == POS_SPD_LO) n_spd_lo = i_rx_byte;
                if (r_count == POS_SPD_HI) n_spd_hi = i_rx_byte;
                if (r_count == POS_TEMP)   n_temp   = i_rx_byte;
                n_crc   = crc_feed(r_crc, i_rx_byte);
                n_count = r_count + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_count     <= 4'd0;
            r_crc       <= 8'd0;
            r_res_valid <= 1'b0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spd_lo <= n_spd_lo;
        r_spd_hi <= n_spd_hi;
        r_temp   <= n_temp;
        r_res    <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== hdl/crcfr_scale.sv =====
// Two-stage scaling pipeline: speed times 55000, then floor divide by 32767;
// temperature times ten. Depends on crcfr_pkg; drives the result channel.
`default_nettype none

module crcfr_scale
    import crcfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_res_valid,
    output logic             o_res_take,
    input  wire t_frame_res  i_res,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [16:0]      o_speed_value,
    output logic [11:0]      o_temp_value
);

    logic        r_a_valid;
    logic [31:0] r_a_prod;
    logic [11:0] r_a_temp10;
    logic        r_b_valid;
    logic [16:0] r_b_speed;
    logic [11:0] r_b_temp;
    logic        en_a, en_b;
    logic [11:0] temp_ext;
    logic [16:0] q0;
    logic [17:0] rem0;
    logic [17:0] q1;
    logic [15:0] rem1;
    logic [17:0] quot;

    assign en_b       = !r_b_valid || !i_stall;
    assign en_a       = !r_a_valid || en_b;
    assign o_res_take = en_a;
    assign temp_ext   = {4'd0, i_res.temp};

    // Divide by 2^15-1: shift gives a low estimate, fold the remainder twice,
    // then one final compare.
    always_comb begin
        q0   = r_a_prod[31:15];
        rem0 = {3'd0, r_a_prod[14:0]} + {1'b0, q0};
        q1   = {1'b0, q0} + {15'd0, rem0[17:15]};
        rem1 = {1'b0, rem0[14:0]} + {13'd0, rem0[17:15]};
        quot = q1 + {17'd0, (rem1 >= {1'b0, SCALE_DIV})};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_res_valid;
            if (en_b) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_prod   <= {16'd0, i_res.raw} * {16'd0, SCALE_MUL};
            r_a_temp10 <= (temp_ext << 3) + (temp_ext << 1);
        end
        if (en_b) begin
            r_b_speed <= quot[16:0];
            r_b_temp  <= r_a_temp10;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_speed_value = r_b_speed;
    assign o_temp_value  = r_b_temp;

endmodule

`default_nettype wire

// ===== hdl/crc8_framed_speed_temp_receiver.sv =====
// Top level of the CRC-8 checked speed/temperature frame receiver.
// Depends on crcfr_pkg, crcfr_frame and crcfr_scale.
//
// Feed received serial bytes on the input channel, one per transfer. While
// hunting, the block drops every byte except the header 0xA5; a header opens
// a nine-byte frame (header included) and any 0xA5 inside the frame is plain
// data. A reflected CRC-8 (poly 0x8C, init 0, no final xor) covers bytes 0
// to 7; when byte 8 matches, one result transfer follows carrying
// floor(speed * 55000 / 32767) from little-endian bytes 4 and 5, and byte 6
// times ten. A failed frame yields nothing. The block takes one byte every
// cycle unless it stalls its input; a result leaves three register stages
// after its check byte (frame result, product, quotient). Input stall rises
// only when all three stages hold results and the output side stalls.
`default_nettype none

module crc8_framed_speed_temp_receiver
    import crcfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [16:0]      o_speed_value,
    output logic [11:0]      o_temp_value
);

    logic       take;
    logic       res_valid;
    logic       res_take;
    t_frame_res res;

    // Hunt, count, check and capture frame fields.
    crcfr_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_take      (take),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // Scale good frames and hold them in the output register.
    crcfr_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .o_res_take    (res_take),
        .i_res         (res),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_speed_value (o_speed_value),
        .o_temp_value  (o_temp_value)
    );

    assign o_stall = !take;

    // Back-pressure reaches the input only through a full, stalled output.
    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output stage free");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_speed_value <= 17'd110001))
        else $error("scaled speed out of range");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temp_value <= 12'd2550))
        else $error("temperature out of range");

endmodule

`default_nettype wire

// ===== bench/tb_crc8_framed_speed_temp_receiver.sv =====
// Testbench for crc8_framed_speed_temp_receiver: drives received bytes, predicts each
// checked frame's speed/temperature reading, and compares every result transfer.
// Depends on hdl/crcfr_pkg.sv and hdl/crc8_framed_speed_temp_receiver.sv.
`timescale 1ns / 100ps

module tb_crc8_framed_speed_temp_receiver;

    // Frame layout and scaling, kept local so the prediction stands on its own.
    localparam logic [7:0]  HEADER     = 8'hA5;
    localparam logic [7:0]  POLY_REFL  = 8'h8C;
    localparam logic [3:0]  CHECK_AT   = 4'd8;
    localparam logic [3:0]  SPEED_LO_AT = 4'd4;
    localparam logic [3:0]  SPEED_HI_AT = 4'd5;
    localparam logic [3:0]  TEMP_AT    = 4'd6;
    localparam logic [32:0] SPEED_MUL  = 33'd55000;
    localparam logic [32:0] SPEED_DIV  = 33'd32767;
    localparam int          RANDOM_FRAME_BYTES = 1600;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [16:0] speed;
        logic [11:0] temp;
    } t_reading;

    // DUT ports; every input is known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [16:0] o_speed_value;
    logic [11:0] o_temp_value;

    crc8_framed_speed_temp_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_speed_value (o_speed_value),
        .o_temp_value  (o_temp_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted receiver state: mirrors the frame tracker inside the block.
    logic       fr_active = 1'b0;
    logic [3:0] fr_count = 4'd0;
    logic [7:0] fr_crc = 8'h00;
    logic [7:0] fr_speed_lo = 8'h00;
    logic [7:0] fr_speed_hi = 8'h00;
    logic [7:0] fr_temp = 8'h00;

    t_reading   reading_q[$];      // readings owed by the block, oldest first
    int         framed_bytes = 0;  // bytes that the frame tracker actually consumed
    int         mismatch_count = 0;
    bit         send_gaps = 1'b1;  // sender inserts random idle cycles
    bit         recv_stalls = 1'b1; // receiver inserts random stall cycles
    int         stall_left = 0;

    // Reflected CRC-8, fed bit by bit, LSB of the data first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ POLY_REFL;
            end
        end
        return c;
    endfunction

    // Advance the predicted state by one accepted byte; queue a reading when
    // the check byte matches the running CRC.
    task automatic track_rx_byte(input logic [7:0] b);
        logic [32:0] product;
        logic [32:0] quotient;
        t_reading    r;
        if (!fr_active) begin
            // Hunting: drop everything but the header.
            if (b == HEADER) begin
                fr_active = 1'b1;
                fr_count  = 4'd1;
                fr_crc    = crc8_step(8'h00, b);
                framed_bytes++;
            end else begin
                fr_count = 4'd0;
            end
        end else begin
            framed_bytes++;
            if (fr_count >= CHECK_AT) begin
                if (b == fr_crc) begin
                    // Full-width product, so the largest raw speed cannot wrap.
                    product  = {17'd0, fr_speed_hi, fr_speed_lo} * SPEED_MUL;
                    quotient = product / SPEED_DIV;
                    r.speed  = quotient[16:0];
                    r.temp   = {4'd0, fr_temp} * 12'd10;
                    reading_q.push_back(r);
                end
                fr_active = 1'b0;
                fr_count  = 4'd0;
            end else begin
                case (fr_count)
                    SPEED_LO_AT: fr_speed_lo = b;
                    SPEED_HI_AT: fr_speed_hi = b;
                    TEMP_AT:     fr_temp = b;
                    default: ;
                endcase
                fr_crc   = crc8_step(fr_crc, b);
                fr_count = fr_count + 4'd1;
            end
        end
    endtask

    // Offer one byte and hold it until the transfer. Called right after a rising
    // edge; leaves valid high so a back-to-back byte needs no second assignment.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        track_rx_byte(b);
    endtask

    // Send a frame: header, body bytes 1..7 (byte k in body[8k-1 -: 8]), check
    // byte. A nonzero flip corrupts the check; n_bytes below 9 cuts the frame.
    task automatic send_frame(input logic [55:0] body, input logic [7:0] flip,
                              input int n_bytes);
        logic [7:0] crc;
        crc = crc8_step(8'h00, HEADER);
        for (int k = 0; k < 7; k++) begin
            crc = crc8_step(crc, body[8*k +: 8]);
        end
        send_byte(HEADER);
        for (int k = 1; k < n_bytes && k < 9; k++) begin
            if (k == 8) begin
                send_byte(crc ^ flip);
            end else begin
                send_byte(body[8*(k-1) +: 8]);
            end
        end
    endtask

    // Drop valid and hold off until every owed reading has come out.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (reading_q.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
        end
    endtask

    // Result side: check each transfer against the oldest prediction, then draw
    // how long to stall before taking the next one.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reading_q.size() == 0) begin
                report_mismatch("unexpected result, speed", -1, int'(o_speed_value));
            end else begin
                want = reading_q.pop_front();
                if (o_speed_value !== want.speed) begin
                    report_mismatch("speed_value", int'(want.speed), int'(o_speed_value));
                end
                if (o_temp_value !== want.temp) begin
                    report_mismatch("temp_value", int'(want.temp), int'(o_temp_value));
                end
            end
            stall_left = recv_stalls ? $urandom_range(0, 5) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_stall <= (stall_left > 0);
    end

    // Speed and temperature at both ends of their range, with headers buried
    // in the filler bytes to show they are taken as plain data.
    task automatic test_field_extremes();
        // bytes 7..1: A5, temp FF, speed FFFF, A5, FF, A5
        send_frame({HEADER, 8'hFF, 8'hFF, 8'hFF, HEADER, 8'hFF, HEADER}, 8'h00, 9);
        send_frame(56'd0, 8'h00, 9);
    endtask

    // A frame with a bad check byte yields nothing; hunting noise afterwards
    // must be dropped.
    task automatic test_check_mismatch();
        send_frame({8'h11, 8'h80, 8'h00, 8'h7F, 8'h33, 8'h22, 8'h11}, 8'h01, 9);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Mostly good frames with random content; the rest are corrupted checks,
    // cut-off frames (the next header then lands inside as data) and noise.
    task automatic test_random_traffic();
        int          stop_at;
        int          kind;
        int          pos;
        bit          paused;
        logic [63:0] rnd;
        logic [55:0] body;
        logic [7:0]  flip;
        stop_at = framed_bytes + RANDOM_FRAME_BYTES;
        paused  = 1'b0;
        while (framed_bytes < stop_at) begin
            // Flip idle modes now and then so long gap-free stretches occur.
            if ($urandom_range(0, 15) == 0) send_gaps = !send_gaps;
            if ($urandom_range(0, 15) == 0) recv_stalls = !recv_stalls;
            if (!paused && framed_bytes >= stop_at - RANDOM_FRAME_BYTES / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end

            rnd  = {$urandom(), $urandom()};
            body = rnd[55:0];
            case ($urandom_range(0, 7))
                0: body[39:24] = 16'h0000;
                1: body[39:24] = 16'hFFFF;
                2: body[39:24] = 16'h7FFF;
                3: body[39:24] = 16'h8000;
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: body[47:40] = 8'h00;
                1: body[47:40] = 8'hFF;
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(0, 6);
                body[8*pos +: 8] = HEADER;
            end

            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                send_frame(body, 8'h00, 9);
            end else if (kind < 16) begin
                flip = 8'($urandom_range(1, 255));
                send_frame(body, flip, 9);
            end else if (kind < 18) begin
                send_frame(body, 8'h00, $urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    initial begin
        int waited;
        // Hold reset, then release it on a rising edge.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_check_mismatch();
        wait_results_drained();
        test_random_traffic();

        // Stop sending, let the pipeline empty, then keep clocking to show that
        // nothing extra comes out.
        i_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (reading_q.size() != 0 && waited < 5000);
        repeat (10) @(posedge i_clk);

        if (reading_q.size() != 0) begin
            report_mismatch("readings never delivered", 0, reading_q.size());
        end
        if (mismatch_count == 0) begin
            $display("crc8_framed_speed_temp_receiver verification clean");
        end else begin
            $display("crc8_framed_speed_temp_receiver verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("crc8_framed_speed_temp_receiver verification failed");
        $finish;
    end

endmodule
